FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define PVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PVA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg
// Types and constants of the polyphonic voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

  localparam int VOICES      = 16;
  localparam int VOICE_IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int STAMP_W     = 32;
  localparam int NOTE_W      = 7;
  localparam int MASK_W      = 16;

  // Release mask for all notes off: one bit for each voice that fits the field.
  localparam logic [MASK_W-1:0] ALL_MASK =
    (VOICES >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((64'd1 << VOICES) - 64'd1);

  localparam logic [1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [1:0] OP_FINISHED = 2'd2;
  localparam logic [1:0] OP_ALL_OFF  = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [NOTE_W-1:0] note;
    logic              has_sample;
    logic [3:0]        finished_voice;
  } in_word_t;

  typedef struct packed {
    logic              assigned;
    logic [3:0]        voice_index;
    logic              stolen;
    logic [NOTE_W-1:0] stolen_note;
    logic [MASK_W-1:0] release_mask;
  } out_word_t;

endpackage

FILE: hw/rtl/polyphonic_voice_allocator_unit.sv
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator_unit
// Voice table with lowest-free allocation and oldest-voice stealing.
// ----------------------------------------------------------------------------
// A note on with a sample and a note off each run a scan: one sequencer
// walks the voice table one entry per cycle through a single 32-bit stamp
// comparator and note comparator, then, once the output register is free,
// writes back (note on only) and loads the result word. A voice-finished
// event, all notes off and a note on without a sample are answered straight
// from the idle state. Input words are taken only while the sequencer is
// idle and the output register is free or being emptied in the same cycle.
module polyphonic_voice_allocator_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pva_pkg::in_word_t in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output pva_pkg::out_word_t out_word
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;

  logic [pva_pkg::VOICES-1:0]      voice_active_r, voice_active_nxt;
  logic [pva_pkg::NOTE_W-1:0]      voice_note_r  [pva_pkg::VOICES];
  logic [pva_pkg::STAMP_W-1:0]     voice_stamp_r [pva_pkg::VOICES];
  logic [pva_pkg::STAMP_W-1:0]     stamp_counter_r, stamp_counter_nxt;

  logic [1:0]                      op_r, op_nxt;
  logic [pva_pkg::NOTE_W-1:0]      note_r, note_nxt;
  logic [pva_pkg::VOICE_IDX_W-1:0] idx_r, idx_nxt;
  logic                            free_found_r, free_found_nxt;
  logic [pva_pkg::VOICE_IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [pva_pkg::VOICE_IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [pva_pkg::STAMP_W-1:0]     best_stamp_r, best_stamp_nxt;
  logic [pva_pkg::NOTE_W-1:0]      best_note_r, best_note_nxt;
  logic [pva_pkg::MASK_W-1:0]      mask_r, mask_nxt;

  logic                            out_valid_r, out_valid_nxt;
  pva_pkg::out_word_t              out_word_r, out_word_nxt;

  logic                            in_take;
  logic                            out_free;
  logic                            cur_active;
  logic [pva_pkg::NOTE_W-1:0]      cur_note;
  logic [pva_pkg::STAMP_W-1:0]     cur_stamp;
  logic                            scan_last;
  logic [pva_pkg::VOICE_IDX_W-1:0] pick_idx;
  logic                            wr_en;
  logic [pva_pkg::VOICE_IDX_W-1:0] fin_idx;
  logic                            fin_in_range;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // One table entry is looked at per cycle.
  assign cur_active = voice_active_r[idx_r];
  assign cur_note   = voice_note_r[idx_r];
  assign cur_stamp  = voice_stamp_r[idx_r];
  assign scan_last  = (idx_r == pva_pkg::VOICE_IDX_W'(pva_pkg::VOICES - 1));

  assign pick_idx     = free_found_r ? free_idx_r : best_idx_r;
  assign fin_in_range = (32'(in_word.finished_voice) < 32'(pva_pkg::VOICES));
  assign fin_idx      = pva_pkg::VOICE_IDX_W'(in_word.finished_voice);

  always_comb begin
    state_nxt         = state_r;
    voice_active_nxt  = voice_active_r;
    stamp_counter_nxt = stamp_counter_r;
    op_nxt            = op_r;
    note_nxt          = note_r;
    idx_nxt           = idx_r;
    free_found_nxt    = free_found_r;
    free_idx_nxt      = free_idx_r;
    best_idx_nxt      = best_idx_r;
    best_stamp_nxt    = best_stamp_r;
    best_note_nxt     = best_note_r;
    mask_nxt          = mask_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_word_nxt      = out_word_r;
    wr_en             = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          op_nxt         = in_word.op;
          note_nxt       = in_word.note;
          idx_nxt        = '0;
          free_found_nxt = 1'b0;
          mask_nxt       = '0;
          out_word_nxt   = '0;
          priority if (in_word.op == pva_pkg::OP_NOTE_OFF ||
                       (in_word.op == pva_pkg::OP_NOTE_ON && in_word.has_sample)) begin
            state_nxt = ST_SCAN;
          end else begin
            out_valid_nxt = 1'b1;
            if (in_word.op == pva_pkg::OP_ALL_OFF) begin
              out_word_nxt.release_mask = pva_pkg::ALL_MASK;
            end
            if (in_word.op == pva_pkg::OP_FINISHED && fin_in_range) begin
              voice_active_nxt[fin_idx] = 1'b0;
            end
          end
        end
      end

      ST_SCAN: begin
        if (!free_found_r && !cur_active) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = idx_r;
        end
        // Strict compare keeps the lowest index among equal stamps.
        if (idx_r == '0 || cur_stamp < best_stamp_r) begin
          best_idx_nxt   = idx_r;
          best_stamp_nxt = cur_stamp;
          best_note_nxt  = cur_note;
        end
        if (cur_active && cur_note == note_r) begin
          mask_nxt = mask_r | (pva_pkg::MASK_W'(1) << idx_r);
        end
        idx_nxt = idx_r + 1'b1;
        if (scan_last) begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_word_nxt  = '0;
          if (op_r == pva_pkg::OP_NOTE_ON) begin
            wr_en                    = 1'b1;
            stamp_counter_nxt        = stamp_counter_r + 1'b1;
            voice_active_nxt[pick_idx] = 1'b1;
            out_word_nxt.assigned    = 1'b1;
            out_word_nxt.voice_index = 4'(pick_idx);
            out_word_nxt.stolen      = !free_found_r;
            out_word_nxt.stolen_note = free_found_r ? '0 : best_note_r;
          end else begin
            out_word_nxt.release_mask = mask_r;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      voice_active_r  <= '0;
      stamp_counter_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      voice_active_r  <= voice_active_nxt;
      stamp_counter_r <= stamp_counter_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // Note and stamp entries only matter for active voices, so they need no reset.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    note_r       <= note_nxt;
    idx_r        <= idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_stamp_r <= best_stamp_nxt;
    best_note_r  <= best_note_nxt;
    mask_r       <= mask_nxt;
    out_word_r   <= out_word_nxt;
    if (wr_en) begin
      voice_note_r[pick_idx]  <= note_r;
      voice_stamp_r[pick_idx] <= stamp_counter_nxt;
    end
  end

endmodule

FILE: hw/rtl/pva_checker.sv
// ----------------------------------------------------------------------------
// pva_checker
// Port-level checks of the voice allocator, bound to the allocator unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pva_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input pva_pkg::out_word_t out_word
);

  `PVA_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output word valid right after reset")
  `PVA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_word), "stalled output word changed")
  `PVA_ASSERT(a_stolen_needs_assign, out_valid && out_word.stolen |-> out_word.assigned, "stolen voice reported without an assignment")
  `PVA_ASSERT(a_assign_no_mask, out_valid && out_word.assigned |-> out_word.release_mask == '0, "note on word carries a release mask")
  `PVA_ASSERT(a_unassigned_clean, out_valid && !out_word.assigned |-> out_word.voice_index == '0 && !out_word.stolen && out_word.stolen_note == '0, "unassigned word carries voice fields")

endmodule

bind polyphonic_voice_allocator_unit pva_checker u_pva_checker (.*);
